FILE: sv/sil_pkg.sv
// ---------------------------------------------------------------------------
// Sorted insertion list package
// Sizes, status codes and the insert command shared by the list modules.
// ---------------------------------------------------------------------------
`default_nettype none

package sil_pkg;

  localparam int CAPACITY     = 64;
  localparam int PAYLOAD_BITS = 16;
  localparam int KEY_W        = 5;
  localparam int CNT_W        = $clog2(CAPACITY + 1);
  localparam int GROUP        = 8;
  localparam int NGRP         = (CAPACITY + GROUP - 1) / GROUP;
  localparam logic [KEY_W-1:0] MAX_HOUR = KEY_W'(24);

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_BAD_KEY = 2'd2,
    ST_BAD_POS = 2'd3
  } status_t;

  typedef struct packed {
    logic                    en;
    logic [KEY_W-1:0]        key;
    logic [PAYLOAD_BITS-1:0] pay;
  } ins_t;

endpackage

`default_nettype wire

FILE: sv/sorted_insertion_list.sv
// ---------------------------------------------------------------------------
// Sorted insertion list
// Bounded list of entries kept in ascending hour order, with insert and read.
// ---------------------------------------------------------------------------
// Items enter on the s_axis channel. tuser selects the operation: 0 inserts
// an entry with the given hour key and payload, 1 reads the entry at a
// position. Each item gives exactly one result item on m_axis with a status,
// the entry count after the item, and for a good read the key and payload.
// An insert is done by a row of cells: every cell compares its key with the
// new key and the cells from the insert point on shift in the same cycle,
// so an insert result is registered in the cycle after the item is taken.
// A read goes through the position register, the registered groups of the
// read tree and the output register. One item is worked on at a time: a
// read holds off new items until its result is in the output register.
// When the receiver stalls, the result holds in the output register and no
// new item is taken until it leaves. Reset empties the list and the output
// register; the stored keys and payloads are not cleared.
// ---------------------------------------------------------------------------
`default_nettype none

module sorted_insertion_list (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // hour_key[4:0], entry_payload[20:5], read_position[26:21], zero fill
  input  wire  [31:0] s_axis_tdata,
  // func[0]
  input  wire  [0:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // status[1:0], entry_count[8:2], read_hour[13:9], read_payload[29:14],
  // zero fill
  output logic [31:0] m_axis_tdata
);
  import sil_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD_TREE,
    S_RD_OUT
  } state_t;

  state_t             state;
  logic [CNT_W-1:0]   count;
  logic [5:0]         pos_q;
  logic               rd_bad;

  logic               accept;
  logic               out_free;
  logic               out_load;
  logic               is_read;
  logic [KEY_W-1:0]   in_key;
  logic [15:0]        in_pay;
  logic [5:0]         in_pos;
  logic               full;
  logic               key_bad;
  ins_t               ins;

  logic [CAPACITY-1:0]                   occ;
  logic [CAPACITY-1:0]                   tail;
  logic [CAPACITY-1:0]                   sel;
  logic [CAPACITY-1:0]                   gt;
  logic [CAPACITY-1:0][KEY_W-1:0]        cell_key;
  logic [CAPACITY-1:0][PAYLOAD_BITS-1:0] cell_pay;
  logic [CAPACITY-1:0][KEY_W-1:0]        rd_key;
  logic [CAPACITY-1:0][PAYLOAD_BITS-1:0] rd_pay;
  logic [KEY_W-1:0]                      tree_key;
  logic [PAYLOAD_BITS-1:0]               tree_pay;

  assign is_read  = s_axis_tuser[0];
  assign in_key   = s_axis_tdata[4:0];
  assign in_pay   = s_axis_tdata[20:5];
  assign in_pos   = s_axis_tdata[26:21];
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = (state == S_IDLE) && out_free;
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_load = (accept && !is_read) || ((state == S_RD_OUT) && out_free);
  assign full     = (32'(count) == CAPACITY);
  assign key_bad  = (in_key > MAX_HOUR);

  assign ins.en  = accept && !is_read && !full && !key_bad;
  assign ins.key = in_key;
  assign ins.pay = PAYLOAD_BITS'(in_pay);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign occ[i]  = 32'(count) > i;
    assign tail[i] = 32'(count) == i;
    assign sel[i]  = 32'(pos_q) == i;

    if (i == 0) begin : g_first
      sil_cell u_cell (
        .clk      (clk),
        .ins      (ins),
        .occ      (occ[i]),
        .tail     (tail[i]),
        .sel      (sel[i]),
        .left_gt  (1'b0),
        .left_key ('0),
        .left_pay ('0),
        .gt       (gt[i]),
        .key      (cell_key[i]),
        .pay      (cell_pay[i]),
        .rd_key   (rd_key[i]),
        .rd_pay   (rd_pay[i])
      );
    end else begin : g_rest
      sil_cell u_cell (
        .clk      (clk),
        .ins      (ins),
        .occ      (occ[i]),
        .tail     (tail[i]),
        .sel      (sel[i]),
        .left_gt  (gt[i-1]),
        .left_key (cell_key[i-1]),
        .left_pay (cell_pay[i-1]),
        .gt       (gt[i]),
        .key      (cell_key[i]),
        .pay      (cell_pay[i]),
        .rd_key   (rd_key[i]),
        .rd_pay   (rd_pay[i])
      );
    end
  end

  sil_read_tree u_tree (
    .clk      (clk),
    .cell_key (rd_key),
    .cell_pay (rd_pay),
    .key      (tree_key),
    .pay      (tree_pay)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      count         <= '0;
      m_axis_tvalid <= 1'b0;
      m_axis_tdata  <= '0;
      pos_q         <= '0;
      rd_bad        <= 1'b0;
    end else begin
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (is_read) begin
              pos_q  <= in_pos;
              rd_bad <= (32'(in_pos) >= 32'(count));
              state  <= S_RD_TREE;
            end else begin
              if (full) begin
                m_axis_tdata <= {2'b0, 16'b0, 5'b0, 7'(count), ST_FULL};
              end else if (key_bad) begin
                m_axis_tdata <= {2'b0, 16'b0, 5'b0, 7'(count), ST_BAD_KEY};
              end else begin
                count        <= count + 1'b1;
                m_axis_tdata <= {2'b0, 16'b0, 5'b0, 7'(count + 1'b1), ST_OK};
              end
            end
          end
        end
        S_RD_TREE: begin
          state <= S_RD_OUT;
        end
        S_RD_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
            if (rd_bad) begin
              m_axis_tdata <= {2'b0, 16'b0, 5'b0, 7'(count), ST_BAD_POS};
            end else begin
              m_axis_tdata <= {2'b0, 16'(tree_pay), tree_key, 7'(count), ST_OK};
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: sv/sil_cell.sv
// ---------------------------------------------------------------------------
// Sorted insertion list cell
// Holds one entry, compares it with the new key and takes either the entry
// of its left neighbor or the new entry when an insert shifts the list.
// ---------------------------------------------------------------------------
`default_nettype none

module sil_cell (
  input  wire                          clk,
  input  sil_pkg::ins_t                ins,
  input  wire                          occ,
  input  wire                          tail,
  input  wire                          sel,
  input  wire                          left_gt,
  input  wire  [sil_pkg::KEY_W-1:0]    left_key,
  input  wire  [sil_pkg::PAYLOAD_BITS-1:0] left_pay,
  output logic                         gt,
  output logic [sil_pkg::KEY_W-1:0]    key,
  output logic [sil_pkg::PAYLOAD_BITS-1:0] pay,
  output logic [sil_pkg::KEY_W-1:0]    rd_key,
  output logic [sil_pkg::PAYLOAD_BITS-1:0] rd_pay
);
  import sil_pkg::*;

  assign gt     = occ && (key > ins.key);
  assign rd_key = sel ? key : '0;
  assign rd_pay = sel ? pay : '0;

  always_ff @(posedge clk) begin
    if (ins.en) begin
      if (left_gt) begin
        key <= left_key;
        pay <= left_pay;
      end else if (gt || tail) begin
        key <= ins.key;
        pay <= ins.pay;
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/sil_read_tree.sv
// ---------------------------------------------------------------------------
// Sorted insertion list read tree
// Collects the one selected cell through registered groups of eight and a
// final combinational merge of the group registers.
// ---------------------------------------------------------------------------
`default_nettype none

module sil_read_tree (
  input  wire                                        clk,
  input  wire  [sil_pkg::CAPACITY-1:0][sil_pkg::KEY_W-1:0]        cell_key,
  input  wire  [sil_pkg::CAPACITY-1:0][sil_pkg::PAYLOAD_BITS-1:0] cell_pay,
  output logic [sil_pkg::KEY_W-1:0]                  key,
  output logic [sil_pkg::PAYLOAD_BITS-1:0]           pay
);
  import sil_pkg::*;

  logic [NGRP-1:0][KEY_W-1:0]        grp_key;
  logic [NGRP-1:0][PAYLOAD_BITS-1:0] grp_pay;
  logic [NGRP-1:0][KEY_W-1:0]        grp_key_next;
  logic [NGRP-1:0][PAYLOAD_BITS-1:0] grp_pay_next;

  always_comb begin
    grp_key_next = '0;
    grp_pay_next = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      grp_key_next[i / GROUP] = grp_key_next[i / GROUP] | cell_key[i];
      grp_pay_next[i / GROUP] = grp_pay_next[i / GROUP] | cell_pay[i];
    end
  end

  always_ff @(posedge clk) begin
    grp_key <= grp_key_next;
    grp_pay <= grp_pay_next;
  end

  always_comb begin
    key = '0;
    pay = '0;
    for (int g = 0; g < NGRP; g++) begin
      key = key | grp_key[g];
      pay = pay | grp_pay[g];
    end
  end

endmodule

`default_nettype wire
